/* hw/rtl/sitda_pkg.sv */
// shared types and constants for the integer to decimal text converter
package sitda_pkg;
	localparam int ValW = 32;
	localparam int NumDigits = 10;
	localparam int CharW = 6;
	localparam logic [CharW-1:0] ChZero = 6'd48;
	localparam logic [CharW-1:0] ChMinus = 6'd45;
	typedef logic [3:0] bcd_t;
	typedef bcd_t [NumDigits-1:0] digits_t;
	// one binary bit shifted into a bcd register with add-3 correction
	function automatic logic [4*NumDigits-1:0] dd_step(input logic [4*NumDigits-1:0] b,
			input logic bit_in);
		logic [4*NumDigits-1:0] t;
		t = b;
		for (int d = 0; d < NumDigits; d++) begin
			if (t[4*d +: 4] >= 4'd5) t[4*d +: 4] = t[4*d +: 4] + 4'd3;
		end
		return {t[4*NumDigits-2:0], bit_in};
	endfunction
endpackage

/* hw/rtl/sitda_if.sv */
// valid/ready channel interface
interface sitda_if #(parameter int W = 1) (input logic clk);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hw/rtl/sitda_conv.sv */
// pipelined double-dabble: eight input bits per stage, four stages
module sitda_conv import sitda_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [ValW-1:0] in_value,
	output logic out_valid,
	input logic out_ready,
	output logic out_neg,
	output logic [4*NumDigits-1:0] out_bcd
);
	logic [3:0] v_q;
	logic [3:0] adv;
	logic [ValW-1:0] mag_q [4];
	logic [4*NumDigits-1:0] bcd_q [4];
	logic neg_q [4];
	logic [ValW-1:0] mag_in;
	logic [4*NumDigits-1:0] nxt [4];

	assign adv[3] = !v_q[3] || out_ready;
	assign adv[2] = !v_q[2] || adv[3];
	assign adv[1] = !v_q[1] || adv[2];
	assign adv[0] = !v_q[0] || adv[1];
	assign in_ready = adv[0];
	assign mag_in = in_value[ValW-1] ? (~in_value + 1'b1) : in_value;

	always_comb begin
		// first stage starts from an empty bcd register
		nxt[0] = '0;
		for (int k = 0; k < 8; k++) begin
			nxt[0] = dd_step(nxt[0], mag_in[ValW-1-k]);
		end
		for (int s = 1; s < 4; s++) begin
			nxt[s] = bcd_q[s-1];
			for (int k = 0; k < 8; k++) begin
				nxt[s] = dd_step(nxt[s], mag_q[s-1][ValW-1-k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0]) v_q[0] <= in_valid;
			for (int s = 1; s < 4; s++) if (adv[s]) v_q[s] <= v_q[s-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			mag_q[0] <= mag_in << 8;
			bcd_q[0] <= nxt[0];
			neg_q[0] <= in_value[ValW-1];
		end
		for (int s = 1; s < 4; s++) begin
			if (adv[s]) begin
				mag_q[s] <= mag_q[s-1] << 8;
				bcd_q[s] <= nxt[s];
				neg_q[s] <= neg_q[s-1];
			end
		end
	end

	assign out_valid = v_q[3];
	assign out_neg = neg_q[3];
	assign out_bcd = bcd_q[3];
endmodule

/* hw/rtl/sitda_ser.sv */
// character serializer: sign, then digits without leading zeros
module sitda_ser import sitda_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic in_neg,
	input logic [4*NumDigits-1:0] in_bcd,
	output logic out_valid,
	input logic out_ready,
	output logic [CharW-1:0] out_char,
	output logic out_last
);
	logic busy_q;
	logic sign_q;
	logic [3:0] idx_q;
	logic [4*NumDigits-1:0] bcd_q;
	logic [3:0] top;
	logic fire;

	// highest nonzero digit, zero gives digit 0
	always_comb begin
		top = '0;
		for (int d = 0; d < NumDigits; d++) if (in_bcd[4*d +: 4] != 4'd0) top = 4'(d);
	end

	assign out_valid = busy_q;
	assign fire = busy_q && out_ready;
	assign out_last = !sign_q && idx_q == 4'd0;
	assign out_char = sign_q ? ChMinus : ChZero + {2'b00, bcd_q[4*idx_q +: 4]};
	assign in_ready = !busy_q || (fire && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			sign_q <= 1'b0;
			idx_q <= '0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
			sign_q <= in_neg;
			idx_q <= top;
		end else if (fire) begin
			if (sign_q) sign_q <= 1'b0;
			else if (idx_q == 4'd0) busy_q <= 1'b0;
			else idx_q <= idx_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) bcd_q <= in_bcd;
	end
endmodule

/* hw/rtl/signed_int_to_decimal_ascii.sv */
// top level of the signed 32-bit integer to decimal ascii converter
// Each input beat carries a signed 32-bit value; the block returns its
// decimal text one character per output beat, most significant first, with
// a leading '-' for negatives, no leading zeros, and is_last on the final
// character. A four-stage double-dabble pipeline converts the magnitude,
// then a serializer emits 1 to 11 characters, one per cycle while the
// receiver is ready; the serializer's single output port sets that rate,
// while the pipeline already accepts the following values. Each value
// passes the pipeline stage registers, then the serializer's registers.
module signed_int_to_decimal_ascii import sitda_pkg::*; (
	input logic clk,
	input logic arst_n,
	sitda_if.sink in_ch,
	sitda_if.source out_ch
);
	logic c_valid;
	logic c_ready;
	logic c_neg;
	logic [4*NumDigits-1:0] c_bcd;
	logic [CharW-1:0] ch;
	logic last;

	// binary to bcd pipeline
	sitda_conv u_conv (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_value(in_ch.data),
		.out_valid(c_valid), .out_ready(c_ready), .out_neg(c_neg), .out_bcd(c_bcd)
	);

	// sign and digits out one beat at a time
	sitda_ser u_ser (
		.clk(clk), .arst_n(arst_n),
		.in_valid(c_valid), .in_ready(c_ready), .in_neg(c_neg), .in_bcd(c_bcd),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_char(ch), .out_last(last)
	);

	// payload: {is_last, character}
	assign out_ch.data = {last, ch};
endmodule

/* sim/signed_int_to_decimal_ascii_chk.sv */
// checker: predicts the decimal text of each accepted value and compares output beats
module signed_int_to_decimal_ascii_chk import sitda_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [ValW-1:0] in_data,
	input logic out_valid,
	input logic out_ready,
	input logic [CharW:0] out_data,
	output int fail_count,
	output int pending_chars
);
	timeunit 1ns;
	timeprecision 1ps;

	// is_last sits above the character in the payload
	typedef struct packed {
		logic is_last;
		logic [CharW-1:0] character;
	} char_beat_t;

	char_beat_t char_q[$];

	// builds the expected characters of one value
	task automatic queue_text(input logic [ValW-1:0] raw);
		logic [ValW-1:0] mag;
		logic [3:0] dig[$];
		char_beat_t b;
		mag = raw[ValW-1] ? (~raw + 1'b1) : raw;
		do begin
			dig.push_front(4'(mag % 10));
			mag = mag / 10;
		end while (mag != 0);
		if (raw[ValW-1]) begin
			b.character = ChMinus;
			b.is_last = 1'b0;
			char_q.push_back(b);
		end
		for (int i = 0; i < dig.size(); i++) begin
			b.character = ChZero + CharW'(dig[i]);
			b.is_last = (i == dig.size() - 1);
			char_q.push_back(b);
		end
	endtask

	initial fail_count = 0;
	assign pending_chars = char_q.size();

	always @(posedge clk) begin
		char_beat_t got, exp_b;
		if (arst_n) begin
			if (in_valid && in_ready) queue_text(in_data);
			if (out_valid && out_ready) begin
				got = out_data;
				if (char_q.size() == 0) begin
					$error("character beat with nothing expected: %0d", got.character);
					fail_count++;
				end else begin
					exp_b = char_q.pop_front();
					if (got.character !== exp_b.character) begin
						$error("character: expected %0d actual %0d", exp_b.character,
							got.character);
						fail_count++;
					end
					if (got.is_last !== exp_b.is_last) begin
						$error("is_last: expected %0d actual %0d", exp_b.is_last, got.is_last);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

/* sim/signed_int_to_decimal_ascii_tb.sv */
// testbench top: stimulus, receiver stalls and verdict for the decimal text converter
module signed_int_to_decimal_ascii_tb;
	import sitda_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending_chars;
	bit quiet_phase;     // no idling near the end
	bit hold_output;     // long receiver hold-off

	sitda_if #(ValW) in_ch(clk);
	// payload packs is_last above the character
	sitda_if #(CharW + 1) out_ch(clk);

	signed_int_to_decimal_ascii i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	signed_int_to_decimal_ascii_chk i_chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_data(in_ch.data),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_data(out_ch.data),
		.fail_count(fail_count),
		.pending_chars(pending_chars)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// random values with magnitudes spread across every digit count
	function automatic logic [ValW-1:0] pick_value();
		logic [ValW-1:0] v;
		int sel;
		sel = $urandom_range(0, 9);
		v = $urandom();
		if (sel < 6) v = v >> $urandom_range(0, 31);
		else if (sel == 6) v = ~(v >> $urandom_range(0, 31));  // small negatives
		if (sel < 7 && $urandom_range(0, 1)) v = ~v + 1'b1;
		return v;
	endfunction

	// offer one beat, with an occasional random gap first
	task automatic send_value(input logic [ValW-1:0] v);
		int gap;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= v;
		// ready is looked at mid-cycle, where it is settled for the coming edge
		@(negedge clk);
		while (!in_ch.ready) @(negedge clk);
		@(posedge clk);
	endtask

	// receiver: random stall bursts, and one long hold-off while inputs keep coming
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_output) begin
				out_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_output = 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 10);
				out_ch.ready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [ValW-1:0] directed[$];
		int wait_cycles;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		arst_n = 1'b0;
		quiet_phase = 1'b0;
		hold_output = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, zero, digit-count boundaries, every digit and the most negative value
		directed = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0001, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100, 32'd999999999,
			32'd1000000000, -32'sd1000000000, 32'd1234567890, -32'sd987654321,
			32'hAAAA_AAAA, 32'h5555_5555};
		foreach (directed[i]) send_value(directed[i]);

		// long receiver hold-off so the pipeline fills and backs up the input
		hold_output = 1'b1;
		for (int i = 0; i < 40; i++) send_value(pick_value());

		for (int i = 0; i < 112; i++) begin
			if (i == 90) quiet_phase = 1'b1;
			send_value(pick_value());
		end
		in_ch.valid <= 1'b0;

		wait_cycles = 0;
		while (pending_chars != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_chars == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("*** FAILED ***");
		$finish;
	end
endmodule

/* signed_int_to_decimal_ascii.f */
hw/rtl/sitda_pkg.sv
hw/rtl/sitda_if.sv
hw/rtl/sitda_conv.sv
hw/rtl/sitda_ser.sv
hw/rtl/signed_int_to_decimal_ascii.sv
sim/signed_int_to_decimal_ascii_chk.sv
sim/signed_int_to_decimal_ascii_tb.sv
